[rtl/core/exp_smoother_with_time_constant_defines.svh]
// Assertion macros used by the checker file of the smoother.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef EXP_SMOOTHER_WITH_TIME_CONSTANT_DEFINES_SVH
`define EXP_SMOOTHER_WITH_TIME_CONSTANT_DEFINES_SVH

// Same-cycle implication.
`define ESTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ests_pkg.sv]
`default_nettype none

package ests_pkg;

  localparam int TARGET_W = 32;
  localparam int TIME_W   = 20;
  localparam int RATE_W   = 19;
  localparam int POLE_W   = 24;

  localparam logic [RATE_W-1:0] RATE_DEFAULT = 19'd48000;

  // Cubic coefficients and bias in unsigned Q32.
  localparam logic [31:0] K_A0 = 32'd4294950116;
  localparam logic [31:0] K_A1 = 32'd134266330;
  localparam logic [31:0] K_A2 = 32'd2073387;
  localparam logic [31:0] K_A3 = 32'd25770;
  // Bias plus the rounding half for the step down to Q0.24.
  localparam logic [32:0] BIAS_RND = 33'd549884;
  localparam logic [POLE_W-1:0] POLE_MAX = 24'hFFFFFF;

  // time * rate and the numerator of the reciprocal.
  localparam int D_W   = 39;
  localparam int NUM_W = 47;
  localparam int QUO_W = 33;
  localparam logic [D_W-1:0]   D_MIN    = 39'd16000;
  localparam logic [NUM_W-1:0] NUM_BASE = 47'd16000 << 32;

  // Shared shift-add multiplier.
  localparam int MCAND_W  = 34;
  localparam int MPLIER_W = 33;
  localparam int PROD_W   = MCAND_W + 1 + MPLIER_W;
  localparam int STEP_W   = 6;
  localparam logic [STEP_W-1:0] MUL_STEPS  = 6'd33;
  localparam logic [STEP_W-1:0] FILT_STEPS = 6'd24;
  localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd47;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSTART,
    ST_MULD,
    ST_DIV,
    ST_POLY,
    ST_FSTART,
    ST_FILT,
    ST_HOLD
  } ests_state_e;

  // Multiply in flight while the pole polynomial is evaluated.
  typedef enum logic [2:0] {
    OP_A2,
    OP_A1,
    OP_A0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_SQ4,
    OP_SQ5
  } ests_op_e;

  typedef struct packed {
    logic                        start;
    logic signed [MCAND_W-1:0]   mcand;
    logic        [MPLIER_W-1:0]  mplier;
    logic        [STEP_W-1:0]    steps;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [D_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/ests_if.sv]
`default_nettype none

interface ests_in_if
  import ests_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] target;
  logic        [TIME_W-1:0]   time_sixteenths_ms;

  modport source (output valid, output target, output time_sixteenths_ms, input ready);
  modport sink   (input valid, input target, input time_sixteenths_ms, output ready);
endinterface

interface ests_out_if
  import ests_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [TARGET_W-1:0] smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink   (input valid, input smoothed, output ready);
endinterface

interface ests_cfg_if
  import ests_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] sample_rate;

  modport source (output valid, output sample_rate, input ready);
  modport sink   (input valid, input sample_rate, output ready);
endinterface

`default_nettype wire

[rtl/core/ests_mul.sv]
`default_nettype none

module ests_mul
  import ests_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [PROD_W-1:0]         p_q, p_d;
  logic signed [MCAND_W-1:0] a_q, a_d;
  logic [STEP_W-1:0]         cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic signed [MCAND_W:0]   upper;
  logic signed [MCAND_W:0]   sum;

  // One multiplier bit per cycle, LSB first; the signed multiplicand is
  // added to the upper half, then the whole register shifts right.
  always_comb begin
    upper = signed'(p_q[PROD_W-1:MPLIER_W]);
    sum   = p_q[0] ? upper + {a_q[MCAND_W-1], a_q} : upper;

    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      p_d    = {{(MCAND_W+1){1'b0}}, req_i.mplier};
      a_d    = req_i.mcand;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum[MCAND_W], sum, p_q[MPLIER_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = p_q;

endmodule

`default_nettype wire

[rtl/core/ests_div.sv]
`default_nettype none

module ests_div
  import ests_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [D_W-1:0]    rem_q, rem_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [D_W-1:0]    den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [D_W:0]      trial;
  logic [D_W:0]      trial_sub;
  logic              ge;

  // Restoring division, one quotient bit per cycle. The quotient never
  // exceeds 2^32, so only its low bits are kept.
  always_comb begin
    trial     = {rem_q, num_q[NUM_W-1]};
    trial_sub = trial - {1'b0, den_q};
    ge        = (trial >= {1'b0, den_q});

    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
      cnt_d  = DIV_STEPS;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

[rtl/core/exp_smoother_with_time_constant.sv]
// One-pole exponential smoother: each request carries a Q16.16 target and a
// smoothing time in sixteenths of a millisecond, and yields one smoothed
// Q16.16 sample y = c*w + target*(1-c), where w is the previous output. All
// multiplies run through one shared shift-add multiplier that retires one
// bit per cycle, so the block takes one request at a time. A request whose
// time equals the previous one needs only the 24-step filter multiply by the
// Q0.24 pole. A new time first recomputes the pole: one 33-step multiply for
// time*rate, a 47-step divider for the reciprocal, and eight more 33-step
// multiplies for the cubic and its five squarings. A sample_rate write
// recomputes the pole from the last time in the same way and holds off
// requests while it does so. A time of zero, or shorter than one sample,
// makes the block pass the target straight through. A result waiting in the
// output register does not keep the next request from being accepted.
`default_nettype none

module exp_smoother_with_time_constant
  import ests_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ests_cfg_if.sink  cfg_ch,
  ests_in_if.sink   in_ch,
  ests_out_if.source out_ch
);

  ests_state_e                state_q, state_d;
  ests_op_e                   op_q, op_d;
  logic [RATE_W-1:0]          rate_q, rate_d;
  logic [RATE_W-1:0]          rate_eff;
  logic signed [TARGET_W-1:0] w_q, w_d;
  logic signed [TARGET_W-1:0] target_q, target_d;
  logic [TIME_W-1:0]          last_time_q, last_time_d;
  logic [POLE_W-1:0]          pole_q, pole_d;
  logic [QUO_W-1:0]           m_q, m_d;
  logic                       item_q, item_d;
  logic                       out_valid_q, out_valid_d;
  logic [TARGET_W-1:0]        out_data_q, out_data_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  idle;
  logic                  in_acc;
  logic                  cfg_acc;
  logic                  out_free;
  logic [D_W-1:0]        d_val;
  logic [32:0]           mul_round;
  logic [32:0]           horner_k;
  logic [32:0]           horner_sub;
  logic [31:0]           p_next;
  logic [32:0]           bias_sum;
  logic [POLE_W:0]       c_wide;
  logic [POLE_W-1:0]     c_clamp;
  logic signed [32:0]    diff;
  logic [34:0]           q_val;
  logic [TARGET_W-1:0]   y_val;

  ests_mul u_ests_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ests_div u_ests_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign idle     = (state_q == ST_IDLE);
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_q || out_ch.ready;
  assign rate_eff = (rate_q == '0) ? RATE_DEFAULT : rate_q;

  always_comb begin
    d_val     = mul_rsp.prod[D_W-1:0];
    // Q32 product rounded half up.
    mul_round = mul_rsp.prod[64:32] + 33'(mul_rsp.prod[31]);

    unique case (op_q)
      OP_A2:   horner_k = {1'b0, K_A2};
      OP_A1:   horner_k = {1'b0, K_A1};
      default: horner_k = {1'b0, K_A0};
    endcase
    horner_sub = horner_k - mul_round;
    p_next = (op_q == OP_A2 || op_q == OP_A1 || op_q == OP_A0) ?
             horner_sub[31:0] : mul_round[31:0];

    bias_sum = {1'b0, p_next} + BIAS_RND;
    c_wide   = bias_sum[32:8];
    c_clamp  = c_wide[POLE_W] ? POLE_MAX : c_wide[POLE_W-1:0];

    diff = {w_q[TARGET_W-1], w_q} - {target_q[TARGET_W-1], target_q};
    // Product bits sit at prod[67:9] after 24 steps; take the rounded
    // arithmetic shift by 24.
    q_val = mul_rsp.prod[PROD_W-1:33] + 35'(mul_rsp.prod[32]);
    y_val = unsigned'(target_q) + q_val[TARGET_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rate_d      = rate_q;
    w_d         = w_q;
    target_d    = target_q;
    last_time_d = last_time_q;
    pole_d      = pole_q;
    m_d         = m_q;
    item_d      = item_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_data_d  = out_data_q;

    mul_req.start  = 1'b0;
    mul_req.mcand  = '0;
    mul_req.mplier = '0;
    mul_req.steps  = MUL_STEPS;
    div_req.start  = 1'b0;
    div_req.num    = NUM_BASE + {{(NUM_W-D_W+1){1'b0}}, d_val[D_W-1:1]};
    div_req.den    = d_val;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          rate_d  = cfg_ch.sample_rate;
          item_d  = 1'b0;
          state_d = ST_PSTART;
        end else if (in_acc) begin
          target_d = in_ch.target;
          item_d   = 1'b1;
          if (in_ch.time_sixteenths_ms != last_time_q) begin
            last_time_d = in_ch.time_sixteenths_ms;
            state_d     = ST_PSTART;
          end else begin
            state_d = ST_FSTART;
          end
        end
      end
      ST_PSTART: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {{(MCAND_W-TIME_W){1'b0}}, last_time_q};
        mul_req.mplier = {{(MPLIER_W-RATE_W){1'b0}}, rate_eff};
        state_d        = ST_MULD;
      end
      ST_MULD: begin
        if (mul_rsp.done) begin
          if (d_val < D_MIN) begin
            pole_d  = '0;
            state_d = item_q ? ST_FSTART : ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          m_d            = div_rsp.quo;
          mul_req.start  = 1'b1;
          mul_req.mcand  = {{(MCAND_W-32){1'b0}}, K_A3};
          mul_req.mplier = div_rsp.quo;
          op_d           = OP_A2;
          state_d        = ST_POLY;
        end
      end
      ST_POLY: begin
        if (mul_rsp.done) begin
          if (op_q == OP_SQ5) begin
            pole_d  = c_clamp;
            state_d = item_q ? ST_FSTART : ST_IDLE;
          end else begin
            // Horner steps multiply by m; the squarings multiply p by itself.
            mul_req.start  = 1'b1;
            mul_req.mcand  = {{(MCAND_W-32){1'b0}}, p_next};
            mul_req.mplier = (op_q == OP_A2 || op_q == OP_A1) ? m_q : {1'b0, p_next};
            op_d           = ests_op_e'(3'(op_q + 3'd1));
          end
        end
      end
      ST_FSTART: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = {diff[32], diff};
        mul_req.mplier = {{(MPLIER_W-POLE_W){1'b0}}, pole_q};
        mul_req.steps  = FILT_STEPS;
        state_d        = ST_FILT;
      end
      ST_FILT: begin
        if (mul_rsp.done) begin
          w_d = signed'(y_val);
          if (out_free) begin
            out_data_d  = y_val;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_data_d  = unsigned'(w_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_A2;
      rate_q      <= RATE_DEFAULT;
      w_q         <= '0;
      last_time_q <= '0;
      pole_q      <= '0;
      item_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rate_q      <= rate_d;
      w_q         <= w_d;
      last_time_q <= last_time_d;
      pole_q      <= pole_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    m_q        <= m_d;
    out_data_q <= out_data_d;
  end

  assign cfg_ch.ready    = idle;
  assign in_ch.ready     = idle && !cfg_ch.valid;
  assign out_ch.valid    = out_valid_q;
  assign out_ch.smoothed = signed'(out_data_q);

endmodule

`default_nettype wire

[rtl/core/ests_chk.sv]
`default_nettype none
`include "exp_smoother_with_time_constant_defines.svh"

module ests_chk
  import ests_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [TARGET_W-1:0] out_smoothed_i
);

  // A waiting result stays offered and unchanged until it is taken.
  `ESTS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `ESTS_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_smoothed_i), "stalled result changed")

  // Once a request or a rate write is taken, the block is busy with it.
  `ESTS_ASSERT_NXT(a_busy_after_req, (in_valid_i && in_ready_i) || (cfg_valid_i && cfg_ready_i), !in_ready_i && !cfg_ready_i, "ready right after a request")

  // A new result only appears at the end of a busy period.
  `ESTS_ASSERT_IMP(a_result_from_work, $rose(out_valid_i), $past(!in_ready_i), "result without a request in work")

endmodule

bind exp_smoother_with_time_constant ests_chk u_ests_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .cfg_valid_i    (cfg_ch.valid),
  .cfg_ready_i    (cfg_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_smoothed_i (out_ch.smoothed)
);

`default_nettype wire
